@@ rtl/vpa_pkg.sv @@
// Package for the variable-partition allocator: widths, status codes, states.
// No dependencies.
package vpa_pkg;
    localparam int OWNED_ENTRIES_DEF = 16;
    localparam int FREE_ENTRIES_DEF  = 17;
    localparam int ADDRESS_BITS_DEF  = 16;
    localparam int SIZE_W   = 16;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam logic [15:0] MEM_UNITS_RST = 16'd1024;
    localparam logic [15:0] SLICE_FLOOR_RST = 16'd10;

    localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPACT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_UNITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_FLOOR = 2'd2;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_FSCAN, S_GRANT, S_CPICK, S_CCLR, S_CGRANT,
        S_RFIND, S_RSCAN, S_RMERGE, S_RNEW, S_OUT
    } t_state;
endpackage

@@ rtl/variable_partition_allocator.sv @@
// Variable-partition allocator top level: tables, sequencer, stream ports.
// Depends on vpa_pkg.
//
// Use: send requests on the s_axis channel. tdata packs, from bit 0 up:
// req_len[15:0], release_pid[23:16]; tuser carries kind (0 allocate,
// 1 release). One result transfer per request leaves on m_axis with tdata:
// status[2:0], owner_pid[10:3], block_start[26:11], block_size[42:27], zero
// padded to 48 bits. Registers are written on the cfg channel (index 0
// memory_size, 1 fit_policy, 2 minimum_slice) while the block is idle.
// Each request is walked one table entry per cycle through one shared
// compare/add datapath. An allocate scans the owned table for a slot and
// the free table for a fitting entry, then grants; compaction adds one
// placement pass over the owned table per placed block, a clear of the
// free table and a grant. A release searches the owned table and the free
// table, and searches for an empty free entry only when it cannot merge.
// s_axis_tready is high only in idle; the result is held in the output
// register while the receiver stalls, and the next request is taken once
// the result transfer has cleared r_ovalid and the state is back in idle.
// Reset restores memory_size 1024, fit 0, slice 10, one free block.
module variable_partition_allocator #(
    parameter int OWNED_ENTRIES = vpa_pkg::OWNED_ENTRIES_DEF,
    parameter int FREE_ENTRIES  = vpa_pkg::FREE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = vpa_pkg::ADDRESS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_len[15:0], release_pid[23:16]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status, owner_pid, block_start, block_size
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [vpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import vpa_pkg::*;
    localparam int OW = $clog2(OWNED_ENTRIES);
    localparam int FW = $clog2(FREE_ENTRIES);
    localparam int OC = $clog2(OWNED_ENTRIES + 1);
    localparam int FC = $clog2(FREE_ENTRIES + 1);
    localparam int AB = ADDRESS_BITS;
    localparam int TW = AB + FC; // total free space accumulator
    localparam int CW = (TW > 16) ? TW : 16; // compare width

    t_state r_state, n_state;
    logic [1:0]  r_fit;
    logic [15:0] r_slice_floor;
    logic [AB-1:0] r_fs [FREE_ENTRIES];
    logic [AB-1:0] r_fl [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] r_fu;
    logic [PID_W-1:0] r_op [OWNED_ENTRIES];
    logic [AB-1:0] r_os [OWNED_ENTRIES];
    logic [AB-1:0] r_ol [OWNED_ENTRIES];
    logic [OWNED_ENTRIES-1:0] r_ou, r_placed;
    logic [PID_W-1:0] r_pidc;
    logic [15:0] r_size;
    logic [PID_W-1:0] r_rpid;
    logic [OC-1:0] r_oi;   // owned scan index
    logic [FC-1:0] r_fi;   // free scan index
    logic [OW-1:0] r_slot, r_cpick;
    logic          r_have;  // slot/pick found
    logic [FW-1:0] r_pick, r_prev, r_next;
    logic          r_hprev, r_hnext, r_hcp;
    logic [TW-1:0] r_total;
    logic [AB-1:0] r_cursor, r_rstart, r_rlen;
    logic          r_ovalid;
    logic [47:0]   r_odata;

    logic [FW-1:0] fi;
    logic [OW-1:0] oi;
    assign fi = r_fi[FW-1:0];
    assign oi = r_oi[OW-1:0];
    logic s_acc, m_acc, cfg_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_acc = r_ovalid && m_axis_tready;

    // shared compare unit on the current free entry
    logic [AB-1:0] cur_l, cur_s, pk_l, pk_s;
    logic better, fits;
    assign cur_l = r_fl[fi];
    assign cur_s = r_fs[fi];
    assign pk_l = r_fl[r_pick];
    assign pk_s = r_fs[r_pick];
    assign fits = CW'(cur_l) >= CW'(r_size);
    always_comb begin
        if (!r_have) better = 1'b1;
        else if (r_fit == FIT_BEST)
            better = cur_l < pk_l || (cur_l == pk_l && cur_s < pk_s);
        else if (r_fit == FIT_WORST)
            better = cur_l > pk_l || (cur_l == pk_l && cur_s < pk_s);
        else better = cur_s < pk_s;
    end
    logic [AB-1:0] g_dif;
    logic [AB-1:0] size_a;
    assign size_a = AB'(r_size);
    assign g_dif = pk_l - size_a;

    // compaction pick: lowest start among unplaced blocks, ties to lowest index
    logic cp_take, cp_any;
    logic [OW-1:0] cp_w;
    assign cp_take = r_ou[oi] && !r_placed[oi] && (!r_hcp || r_os[oi] < r_os[r_cpick]);
    assign cp_any  = r_hcp || (r_ou[oi] && !r_placed[oi]);
    assign cp_w    = cp_take ? oi : r_cpick;

    logic last_f, last_o;
    assign last_f = (r_fi == FC'(FREE_ENTRIES - 1));
    assign last_o = (r_oi == OC'(OWNED_ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_acc) n_state = s_axis_tuser ? S_RFIND : S_SLOT;
            S_SLOT:   if (r_size == 16'd0) n_state = S_OUT;
                      else if (!r_ou[oi]) n_state = S_FSCAN;
                      else if (last_o) n_state = S_OUT;
            S_FSCAN:  if (last_f) n_state = S_GRANT;
            S_GRANT:  n_state = S_OUT;
            // stay until a pass finds no unplaced block
            S_CPICK:  if (last_o && !cp_any) n_state = S_CCLR;
            S_CCLR:   if (last_f) n_state = S_CGRANT;
            S_CGRANT: n_state = S_OUT;
            S_RFIND:  if (r_ou[oi] && r_op[oi] == r_rpid) n_state = S_RSCAN;
                      else if (last_o) n_state = S_OUT;
            S_RSCAN:  if (last_f) n_state = S_RMERGE;
            S_RMERGE: n_state = (r_hprev || r_hnext) ? S_OUT : S_RNEW;
            S_RNEW:   if (!r_fu[fi] || last_f) n_state = S_OUT;
            S_OUT:    if (!r_ovalid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (r_state == S_GRANT && !r_have)
            n_state = (CW'(r_size) > CW'(r_total)) ? S_OUT : S_CPICK;
    end

    function automatic logic [47:0] pack(logic [2:0] st, logic [7:0] p,
                                         logic [15:0] a, logic [15:0] l);
        pack = {5'd0, l, a, p, st};
    endfunction

    logic [AB-1:0] end_a;
    assign end_a = r_rstart + r_rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fit <= 2'd0;
            r_slice_floor <= SLICE_FLOOR_RST;
            r_pidc <= '0;
            r_ou <= '0;
            r_fu <= FREE_ENTRIES'(1);
            for (int k = 0; k < FREE_ENTRIES; k++) begin
                r_fs[k] <= '0;
                r_fl[k] <= (k == 0) ? AB'(MEM_UNITS_RST) : '0;
            end
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_acc) r_ovalid <= 1'b0;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_MEM_UNITS: begin
                        // drop every block, leave one free block over the new size (none if the size is zero)
                        r_ou <= '0;
                        r_fu <= FREE_ENTRIES'(AB'(i_cfg_data) != '0);
                        r_fs[0] <= '0;
                        r_fl[0] <= AB'(i_cfg_data);
                    end
                    REG_FIT:         r_fit <= i_cfg_data[1:0];
                    REG_SLICE_FLOOR: r_slice_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (s_acc) begin
                    r_size <= s_axis_tdata[15:0];
                    r_rpid <= s_axis_tdata[23:16];
                    r_oi <= '0; r_fi <= '0; r_have <= 1'b0; r_total <= '0;
                    r_hprev <= 1'b0; r_hnext <= 1'b0;
                    if (!s_axis_tuser) r_pidc <= r_pidc + 1'b1;
                end
                S_SLOT: begin
                    if (r_size == 16'd0)
                        r_odata <= pack(ST_NOSPACE, 8'd0, 16'd0, 16'd0);
                    else if (!r_ou[oi]) r_slot <= oi;
                    else if (last_o) r_odata <= pack(ST_FULL, 8'd0, 16'd0, 16'd0);
                    r_oi <= r_oi + 1'b1;
                end
                S_FSCAN: begin
                    if (r_fu[fi]) begin
                        r_total <= r_total + TW'(cur_l);
                        if (fits && better) begin
                            r_pick <= fi; r_have <= 1'b1;
                        end
                    end
                    r_fi <= r_fi + 1'b1;
                end
                S_GRANT, S_CGRANT: if (r_have || r_state == S_CGRANT) begin
                    r_ou[r_slot] <= 1'b1;
                    r_op[r_slot] <= r_pidc;
                    r_os[r_slot] <= pk_s;
                    if (g_dif == '0 || CW'(g_dif) < CW'(r_slice_floor)) begin
                        r_ol[r_slot] <= pk_l;
                        r_fu[r_pick] <= 1'b0;
                        r_fs[r_pick] <= '0; r_fl[r_pick] <= '0;
                        r_odata <= pack(r_state == S_CGRANT ? ST_COMPACT : ST_ALLOC,
                                        r_pidc, 16'(pk_s), 16'(pk_l));
                    end else begin
                        r_ol[r_slot] <= size_a;
                        r_fs[r_pick] <= pk_s + size_a;
                        r_fl[r_pick] <= g_dif;
                        r_odata <= pack(r_state == S_CGRANT ? ST_COMPACT : ST_ALLOC,
                                        r_pidc, 16'(pk_s), r_size);
                    end
                end else begin
                    r_odata <= pack(ST_NOSPACE, 8'd0, 16'd0, 16'd0);
                    r_oi <= '0; r_placed <= '0; r_cursor <= '0;
                    r_hcp <= 1'b0;
                end
                S_CPICK: begin
                    // one pass per placed block: find lowest unplaced start
                    if (last_o) begin
                        r_oi <= '0;
                        r_hcp <= 1'b0;
                        if (cp_any) begin
                            r_placed[cp_w] <= 1'b1;
                            r_os[cp_w] <= r_cursor;
                            r_cursor <= r_cursor + r_ol[cp_w];
                        end
                    end else begin
                        if (cp_take) begin
                            r_cpick <= oi; r_hcp <= 1'b1;
                        end
                        r_oi <= r_oi + 1'b1;
                    end
                    r_fi <= '0;
                end
                S_CCLR: begin
                    r_fu[fi] <= fi == '0;
                    r_fs[fi] <= (fi == '0) ? r_cursor : '0;
                    r_fl[fi] <= (fi == '0) ? AB'(r_total) : '0;
                    r_fi <= r_fi + 1'b1;
                    r_pick <= '0;
                end
                S_RFIND: begin
                    if (r_ou[oi] && r_op[oi] == r_rpid) begin
                        r_rstart <= r_os[oi]; r_rlen <= r_ol[oi];
                        r_ou[oi] <= 1'b0;
                    end else if (last_o)
                        r_odata <= pack(ST_UNKNOWN, r_rpid, 16'd0, 16'd0);
                    r_oi <= r_oi + 1'b1;
                end
                S_RSCAN: begin
                    if (r_fu[fi]) begin
                        if (!r_hprev && cur_s + cur_l == r_rstart) begin
                            r_prev <= fi; r_hprev <= 1'b1;
                        end else if (!r_hnext && cur_s == end_a) begin
                            r_next <= fi; r_hnext <= 1'b1;
                        end
                    end
                    r_fi <= r_fi + 1'b1;
                end
                S_RMERGE: begin
                    r_odata <= pack(ST_REL, r_rpid, 16'(r_rstart), 16'(r_rlen));
                    r_fi <= '0;
                    if (r_hprev) begin
                        r_fl[r_prev] <= r_fl[r_prev] + r_rlen + (r_hnext ? r_fl[r_next] : '0);
                        if (r_hnext) begin
                            r_fu[r_next] <= 1'b0; r_fs[r_next] <= '0; r_fl[r_next] <= '0;
                        end
                    end else if (r_hnext) begin
                        r_fs[r_next] <= r_rstart;
                        r_fl[r_next] <= r_fl[r_next] + r_rlen;
                    end
                end
                S_RNEW: begin
                    if (!r_fu[fi]) begin
                        r_fu[fi] <= 1'b1; r_fs[fi] <= r_rstart; r_fl[fi] <= r_rlen;
                    end
                    r_fi <= r_fi + 1'b1;
                end
                default: ;
            endcase
            if (r_state != S_OUT && n_state == S_OUT) r_ovalid <= 1'b1;
        end
    end
endmodule
